>>> rtl/core/lis_pkg.sv
// Shared types and constants for the loop interval statistics block.
// Depends on nothing; the controller, datapath and top level import it.
package lis_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIV_STEPS = DATA_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] US_PER_MS = 32'd1000;
  localparam logic [DATA_W-1:0] MAX_U32   = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take a new mark and update the running statistics
    logic scale;     // form the scaled total and start the divider
    logic div_step;  // one restoring division step
    logic publish;   // copy the finished result into the output registers
  } lis_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;  // the current division step is the final one
  } lis_status_t;

endpackage

>>> rtl/core/lis_ctrl.sv
// Controller state machine for the loop interval statistics block.
// Depends on lis_pkg for the command and status structs.
module lis_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  lis_pkg::lis_status_t status,
  output lis_pkg::lis_cmd_t    cmd
);
  import lis_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIV,
    ST_PUBLISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The output register can take a result when empty or when being drained.
  assign slot_free = !out_valid_r || out_ready;

  // Next state, registered output flag and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (slot_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/lis_dp.sv
// Datapath for the loop interval statistics block: running statistics,
// scaling multiply, restoring divider and output registers. Depends on lis_pkg.
module lis_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lis_pkg::lis_cmd_t           cmd,
  output lis_pkg::lis_status_t        status,
  input  logic [lis_pkg::DATA_W-1:0]  now_ms,
  output logic [lis_pkg::DATA_W-1:0]  interval,
  output logic [lis_pkg::DATA_W-1:0]  shortest,
  output logic [lis_pkg::DATA_W-1:0]  longest,
  output logic [lis_pkg::DATA_W-1:0]  sample_count,
  output logic [lis_pkg::DATA_W-1:0]  average_us
);
  import lis_pkg::*;

  logic [DATA_W-1:0] last_mark_r, total_r, min_r, max_r, count_r, gap_r;
  logic [DATA_W-1:0] gap_nxt;
  logic [DATA_W-1:0] quot_r, rem_r;
  logic [STEP_W-1:0] step_r;
  logic [DATA_W:0]   trial, diff;
  logic [DATA_W-1:0] interval_r, shortest_r, longest_r, count_out_r, average_r;

  assign gap_nxt = now_ms - last_mark_r;

  // Running statistics, updated once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_mark_r <= '0;
      total_r     <= '0;
      min_r       <= MAX_U32;
      max_r       <= '0;
      count_r     <= '0;
    end else if (cmd.load) begin
      last_mark_r <= now_ms;
      total_r     <= total_r + gap_nxt;
      if (count_r != MAX_U32) begin
        count_r <= count_r + 1'b1;
      end
      if (gap_nxt < min_r) begin
        min_r <= gap_nxt;
      end
      if (gap_nxt > max_r) begin
        max_r <= gap_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gap_r <= gap_nxt;
    end
  end

  // One restoring division step: shift in the next dividend bit and
  // subtract the count when it fits.
  assign trial = {rem_r, quot_r[DATA_W-1]};
  assign diff  = trial - {1'b0, count_r};

  // Scaled total is the dividend; quotient bits shift in from the right.
  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      quot_r <= total_r * US_PER_MS;
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      quot_r <= {quot_r[DATA_W-2:0], !diff[DATA_W]};
      rem_r  <= diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
      step_r <= step_r + 1'b1;
    end
  end

  assign status.div_last = (step_r == STEP_W'(DIV_STEPS - 1));

  // Output registers; a zero count reports a zero average.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      interval_r  <= gap_r;
      shortest_r  <= min_r;
      longest_r   <= max_r;
      count_out_r <= count_r;
      average_r   <= (count_r == '0) ? '0 : quot_r;
    end
  end

  assign interval     = interval_r;
  assign shortest     = shortest_r;
  assign longest      = longest_r;
  assign sample_count = count_out_r;
  assign average_us   = average_r;

endmodule

>>> rtl/core/loop_interval_statistics_top.sv
// Top level of the loop interval statistics block.
// Depends on lis_pkg, lis_ctrl and lis_dp.
//
// Each transaction on the input channel carries a millisecond timestamp and
// produces one result: the interval since the previous mark (the first from
// zero), the shortest and longest intervals so far, a saturating mark count
// and the average interval in microseconds, computed as the 32-bit truncated
// product total*1000 divided by the count. The statistics update at the
// accepting edge, and the result then reaches the output register through
// the scaling multiply, 32 steps of the bit-serial restoring divider and
// the load of the output register. The controller then returns to idle
// before it takes the next mark, so a mark is accepted only after the
// previous one has been published. A new mark is taken while the previous
// result still waits on the output channel. A finished result that finds
// the output register still full holds the block until that register
// drains.
module loop_interval_statistics_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lis_pkg::DATA_W-1:0] in_now_ms,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lis_pkg::DATA_W-1:0] out_interval,
  output logic [lis_pkg::DATA_W-1:0] out_shortest,
  output logic [lis_pkg::DATA_W-1:0] out_longest,
  output logic [lis_pkg::DATA_W-1:0] out_sample_count,
  output logic [lis_pkg::DATA_W-1:0] out_average_us
);
  import lis_pkg::*;

  lis_cmd_t    cmd;
  lis_status_t status;

  // Sequencing of load, scale, divide and publish.
  lis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Statistics registers, divider and output registers.
  lis_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .now_ms       (in_now_ms),
    .interval     (out_interval),
    .shortest     (out_shortest),
    .longest      (out_longest),
    .sample_count (out_sample_count),
    .average_us   (out_average_us)
  );

  // The block is busy right after accepting a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a mark is in progress");

  // A delivered result always counts at least one mark.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample_count != '0)
    else $error("result shows a zero sample count");

  // The reported interval lies between the shortest and longest so far.
  a_interval_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_shortest <= out_interval) && (out_longest >= out_interval))
    else $error("interval outside the shortest and longest bounds");

endmodule

>>> dv/lis_stats_checker.sv
`timescale 1ns / 100ps
// Checker for the loop interval statistics block: watches both channels,
// predicts each result from the accepted marks and compares. Uses lis_pkg.
module lis_stats_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [lis_pkg::DATA_W-1:0] in_now_ms,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [lis_pkg::DATA_W-1:0] out_interval,
  input  logic [lis_pkg::DATA_W-1:0] out_shortest,
  input  logic [lis_pkg::DATA_W-1:0] out_longest,
  input  logic [lis_pkg::DATA_W-1:0] out_sample_count,
  input  logic [lis_pkg::DATA_W-1:0] out_average_us,
  output int                         fail_count,
  output int                         pending,
  output int                         marks_seen,
  output int                         results_seen
);

  localparam int REPORT_MAX = 10;

  typedef logic [lis_pkg::DATA_W-1:0] word_t;

  typedef struct packed {
    word_t interval;
    word_t shortest;
    word_t longest;
    word_t sample_count;
    word_t average_us;
  } lis_stats_t;

  // Running statistics as the block should hold them.
  word_t prev_mark;
  word_t sum_ms;
  word_t min_gap;
  word_t max_gap;
  word_t marks;

  lis_stats_t expected_stats[$];
  int         errors;

  assign fail_count = errors;
  assign pending    = expected_stats.size();

  // Fold one mark into the running statistics and return the result it causes.
  function automatic lis_stats_t next_stats(word_t now);
    lis_stats_t r;
    word_t      gap;
    word_t      scaled;
    gap    = now - prev_mark;
    sum_ms = sum_ms + gap;
    if (marks != lis_pkg::MAX_U32) begin
      marks = marks + 1;
    end
    if (gap > max_gap) begin
      max_gap = gap;
    end
    if (gap < min_gap) begin
      min_gap = gap;
    end
    prev_mark = now;
    // The scaled total is truncated to 32 bits before the division.
    scaled         = sum_ms * lis_pkg::US_PER_MS;
    r.interval     = gap;
    r.shortest     = min_gap;
    r.longest      = max_gap;
    r.sample_count = marks;
    r.average_us   = (marks == '0) ? '0 : scaled / marks;
    return r;
  endfunction

  always @(posedge clk) begin
    lis_stats_t want;
    lis_stats_t got;
    if (!rst_n) begin
      prev_mark    = '0;
      sum_ms       = '0;
      min_gap      = lis_pkg::MAX_U32;
      max_gap      = '0;
      marks        = '0;
      errors       = 0;
      expected_stats.delete();
      marks_seen   <= 0;
      results_seen <= 0;
    end else begin
      // Every accepted mark queues exactly one expected result.
      if (in_valid && in_ready) begin
        expected_stats.push_back(next_stats(in_now_ms));
        marks_seen <= marks_seen + 1;
      end
      // Every accepted result is matched against the oldest expectation.
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        got = '{out_interval, out_shortest, out_longest, out_sample_count, out_average_us};
        if (expected_stats.size() == 0) begin
          errors = errors + 1;
          if (errors <= REPORT_MAX) begin
            $display("%0t: result transaction with nothing expected: %h %h %h %h %h",
                     $realtime, got.interval, got.shortest, got.longest,
                     got.sample_count, got.average_us);
          end
        end else begin
          want = expected_stats.pop_front();
          if (got.interval !== want.interval || got.shortest !== want.shortest ||
              got.longest !== want.longest || got.sample_count !== want.sample_count ||
              got.average_us !== want.average_us) begin
            errors = errors + 1;
            if (errors <= REPORT_MAX) begin
              $display("%0t: mismatch in result %0d", $realtime, results_seen);
              $display("  interval exp %h act %h, shortest exp %h act %h",
                       want.interval, got.interval, want.shortest, got.shortest);
              $display("  longest exp %h act %h, count exp %h act %h, avg exp %h act %h",
                       want.longest, got.longest, want.sample_count, got.sample_count,
                       want.average_us, got.average_us);
            end
          end
        end
      end
    end
  end

endmodule

>>> dv/loop_interval_statistics_top_test.sv
`timescale 1ns / 100ps
// Testbench top for the loop interval statistics block: clock, reset and
// stimulus for both channels, plus the verdict. Uses lis_pkg and lis_stats_checker.
module loop_interval_statistics_top_test;

  localparam int RANDOM_MARKS = 650;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 500;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 50;
  localparam int STEADY_FIRST = 250;
  localparam int STEADY_LAST  = 380;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [lis_pkg::DATA_W-1:0] in_now_ms;
  logic                       out_valid;
  logic                       out_ready;
  logic [lis_pkg::DATA_W-1:0] out_interval;
  logic [lis_pkg::DATA_W-1:0] out_shortest;
  logic [lis_pkg::DATA_W-1:0] out_longest;
  logic [lis_pkg::DATA_W-1:0] out_sample_count;
  logic [lis_pkg::DATA_W-1:0] out_average_us;

  int fail_count;
  int pending;
  int marks_seen;
  int results_seen;

  int   marks_offered = 0;
  bit   steady        = 1'b0;
  bit   hold_done     = 1'b0;
  int   quiet_cycles  = 0;
  logic [lis_pkg::DATA_W-1:0] tick;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  loop_interval_statistics_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_interval     (out_interval),
    .out_shortest     (out_shortest),
    .out_longest      (out_longest),
    .out_sample_count (out_sample_count),
    .out_average_us   (out_average_us)
  );

  lis_stats_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_interval     (out_interval),
    .out_shortest     (out_shortest),
    .out_longest      (out_longest),
    .out_sample_count (out_sample_count),
    .out_average_us   (out_average_us),
    .fail_count       (fail_count),
    .pending          (pending),
    .marks_seen       (marks_seen),
    .results_seen     (results_seen)
  );

  // Offer one mark, idling first at random, and return once it is accepted.
  task automatic send_mark(input logic [lis_pkg::DATA_W-1:0] stamp);
    int gap;
    gap = 0;
    if (!steady) begin
      if ($urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 40);
      end else begin
        while ($urandom_range(0, 99) < 22) begin
          gap = gap + 1;
        end
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_now_ms <= stamp;
    marks_offered = marks_offered + 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Receiver: random back-pressure, one long hold-off while marks keep coming.
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && marks_offered >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 22);
        @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("loop_interval_statistics_top_test: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_now_ms = '0;
    out_ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed marks: field extremes, repeats, wrap of the tick counter,
    // wrap of the total and overflow of the scaled total.
    send_mark(32'h0000_0000);
    send_mark(32'hFFFF_FFFF);
    send_mark(32'h0000_0000);
    send_mark(32'h0000_0000);
    send_mark(32'h8000_0000);
    send_mark(32'h7FFF_FFFF);
    send_mark(32'h0000_03E8);
    send_mark(32'h0041_8937);
    send_mark(32'h0041_8938);
    send_mark(32'hAAAA_AAAA);
    send_mark(32'h5555_5555);
    send_mark(32'hFFFF_FFF0);
    send_mark(32'h0000_0010);
    send_mark(32'h0000_0011);
    send_mark(32'h0000_0023);

    // Random marks: mostly a steady loop with jitter, some long pauses,
    // jumps anywhere in the tick range and steps backwards.
    tick = 32'h0000_0023;
    for (int i = 0; i < RANDOM_MARKS; i++) begin
      int pick;
      pick   = $urandom_range(0, 99);
      steady = (i >= STEADY_FIRST) && (i < STEADY_LAST);
      if (pick < 70) begin
        tick = tick + $urandom_range(0, 40);
      end else if (pick < 85) begin
        tick = tick + $urandom_range(1000, 200000);
      end else if (pick < 95) begin
        tick = $urandom();
      end else begin
        tick = tick - $urandom_range(0, 3);
      end
      send_mark(tick);
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    // Wait for every result, then let the block settle.
    while (results_seen < marks_offered) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d marks and %0d results, with tick and total wrap,", marks_seen,
             results_seen);
    $display("scaled total overflow, random back-pressure and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("loop_interval_statistics_top_test: done, clean");
    end else begin
      $display("loop_interval_statistics_top_test: done, errors");
    end
    $finish;
  end

endmodule
